FILE: rtl/bc128dec_pkg.sv
`default_nettype none

package bc128dec_pkg;

  // Commands from the sequencer to the round datapath.
  typedef struct packed {
    logic blk_load;    // capture a ciphertext word into the state register
    logic key_wr;      // write a round key into the key store
    logic add_only;    // initial key addition
    logic full_round;  // inverse substitution, row shift, column mix, key addition
    logic last_round;  // final round into the output register
  } cmd_t;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam int SLOT_W = 4;
  localparam int HALF_W = 64;
  localparam int BLK_W  = 128;

  localparam logic [7:0] XTIME_POLY = 8'h1b;

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

`default_nettype wire

FILE: rtl/bc128dec_if.sv
`default_nettype none

interface bc128dec_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [bc128dec_pkg::SLOT_W-1:0]    key_slot;
  logic [bc128dec_pkg::HALF_W-1:0]    word_high;
  logic [bc128dec_pkg::HALF_W-1:0]    word_low;

  modport source (output valid, mode, key_slot, word_high, word_low, input ready);
  modport sink (input valid, mode, key_slot, word_high, word_low, output ready);
endinterface

interface bc128dec_out_if;
  logic                               valid;
  logic                               ready;
  logic [bc128dec_pkg::HALF_W-1:0]    plain_high;
  logic [bc128dec_pkg::HALF_W-1:0]    plain_low;

  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

`default_nettype wire

FILE: rtl/block_cipher_128_decrypt_top.sv
// 128-bit block decryption in the equivalent inverse cipher form.
// Input channel in_chan carries one word per handshake: mode 0 writes a
// round key (already in equivalent-inverse form) into slot key_slot, slots
// 0 to ROUND_COUNT; a load to a higher slot is dropped. Mode 1 decrypts one
// ciphertext block with the stored keys and gives one word on out_chan.
// A key load produces nothing on the output.
// A decryption runs the initial key addition and then each round, all on
// a single round unit that reads one key from the key store per cycle.
// The final round writes the plaintext into the output register, which
// drives out_chan. The next word is accepted in the same cycle as the
// final round, so a new block enters only as the previous one completes.
// The plaintext sits in an output register; while it waits, the next block
// is already accepted and computed. If the receiver still stalls when that
// next block reaches its final round, the engine holds there and in_chan
// stays not ready until the output register frees up.
// Reset clears the sequencer and the output valid flag; the key store is
// not cleared, and every slot must be loaded before a block uses it.
`default_nettype none

module block_cipher_128_decrypt_top #(
  parameter int ROUND_COUNT = 10
) (
  input wire logic      clk,
  input wire logic      rst_n,
  bc128dec_in_if.sink   in_chan,
  bc128dec_out_if.source out_chan
);
  import bc128dec_pkg::*;

  localparam int CNT_W = $clog2(ROUND_COUNT + 1);

  cmd_t             cmd;
  logic [CNT_W-1:0] rd_addr;
  logic             in_ready;
  logic             out_valid;

  bc128dec_ctrl #(
    .ROUND_COUNT (ROUND_COUNT),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_ready),
    .in_mode     (in_chan.mode),
    .in_key_slot (in_chan.key_slot),
    .out_valid   (out_valid),
    .out_ready   (out_chan.ready),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  bc128dec_dp #(
    .ROUND_COUNT (ROUND_COUNT),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .key_slot   (in_chan.key_slot),
    .word_high  (in_chan.word_high),
    .word_low   (in_chan.word_low),
    .plain_high (out_chan.plain_high),
    .plain_low  (out_chan.plain_low)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

`default_nettype wire

FILE: rtl/bc128dec_dp.sv
`default_nettype none

module bc128dec_dp #(
  parameter int ROUND_COUNT = 10,
  parameter int CNT_W       = 4
) (
  input  wire logic                              clk,
  input  wire bc128dec_pkg::cmd_t                cmd,
  input  wire logic [CNT_W-1:0]                  rd_addr,
  input  wire logic [bc128dec_pkg::SLOT_W-1:0]   key_slot,
  input  wire logic [bc128dec_pkg::HALF_W-1:0]   word_high,
  input  wire logic [bc128dec_pkg::HALF_W-1:0]   word_low,
  output logic      [bc128dec_pkg::HALF_W-1:0]   plain_high,
  output logic      [bc128dec_pkg::HALF_W-1:0]   plain_low
);
  import bc128dec_pkg::*;

  localparam int SLOTS = ROUND_COUNT + 1;

  logic [BLK_W-1:0] key_mem [SLOTS];
  logic [BLK_W-1:0] key_rd_r;
  logic [BLK_W-1:0] state_r;
  logic [BLK_W-1:0] state_nxt;
  logic [BLK_W-1:0] out_r;
  logic [BLK_W-1:0] out_nxt;
  logic [BLK_W-1:0] sub_shift;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XTIME_POLY : 8'h00);
  endfunction

  // Inverse byte substitution and inverse row shift in one pass.
  function automatic logic [BLK_W-1:0] inv_sub_shift(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLK_W-1-8*(4*c+r) -: 8] = INV_SBOX[s[BLK_W-1-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  // Inverse column mix, built from repeated doubling.
  function automatic logic [BLK_W-1:0] inv_mix(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    logic [7:0] a [4];
    logic [7:0] n [4];
    logic [7:0] b [4];
    logic [7:0] d [4];
    logic [7:0] e [4];
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = s[BLK_W-1-8*(4*c+r) -: 8];
        x2 = xtime(a[r]);
        x4 = xtime(x2);
        x8 = xtime(x4);
        n[r] = x8 ^ a[r];
        b[r] = x8 ^ x2 ^ a[r];
        d[r] = x8 ^ x4 ^ a[r];
        e[r] = x8 ^ x4 ^ x2;
      end
      t[BLK_W-1-8*(4*c+0) -: 8] = e[0] ^ b[1] ^ d[2] ^ n[3];
      t[BLK_W-1-8*(4*c+1) -: 8] = n[0] ^ e[1] ^ b[2] ^ d[3];
      t[BLK_W-1-8*(4*c+2) -: 8] = d[0] ^ n[1] ^ e[2] ^ b[3];
      t[BLK_W-1-8*(4*c+3) -: 8] = b[0] ^ d[1] ^ n[2] ^ e[3];
    end
    return t;
  endfunction

  // Round key store; the read is registered, so the sequencer addresses
  // each key in the cycle before the round that uses it.
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[key_slot[CNT_W-1:0]] <= {word_high, word_low};
    end
    key_rd_r <= key_mem[rd_addr];
  end

  assign sub_shift = inv_sub_shift(state_r);

  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    if (cmd.blk_load) begin
      state_nxt = {word_high, word_low};
    end else if (cmd.add_only) begin
      state_nxt = state_r ^ key_rd_r;
    end else if (cmd.full_round) begin
      state_nxt = inv_mix(sub_shift) ^ key_rd_r;
    end
    if (cmd.last_round) begin
      out_nxt = sub_shift ^ key_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    out_r   <= out_nxt;
  end

  assign plain_high = out_r[BLK_W-1 -: HALF_W];
  assign plain_low  = out_r[HALF_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bc128dec_ctrl.sv
`default_nettype none

module bc128dec_ctrl #(
  parameter int ROUND_COUNT = 10,
  parameter int CNT_W       = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_mode,
  input  wire logic [bc128dec_pkg::SLOT_W-1:0]   in_key_slot,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bc128dec_pkg::cmd_t                     cmd,
  output logic      [CNT_W-1:0]                  rd_addr
);
  import bc128dec_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [CNT_W-1:0]  LAST_RND = CNT_W'(ROUND_COUNT);
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(ROUND_COUNT);

  logic             state_r;
  logic             state_nxt;
  logic [CNT_W-1:0] round_r;
  logic [CNT_W-1:0] round_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_fire;
  logic             dec_fire;
  logic             at_last;
  logic             fin_ok;

  assign at_last  = (state_r == ST_RUN) && (round_r == LAST_RND);
  // The final round may only complete when the output register is free
  // or being emptied in this cycle.
  assign fin_ok   = at_last && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || fin_ok;
  assign in_fire  = in_valid && in_ready;
  assign dec_fire = in_fire && (in_mode == MODE_DECRYPT);

  always_comb begin
    cmd            = '0;
    cmd.blk_load   = dec_fire;
    cmd.key_wr     = in_fire && (in_mode == MODE_LOAD) && (in_key_slot <= TOP_SLOT);
    cmd.add_only   = (state_r == ST_RUN) && (round_r == '0);
    cmd.full_round = (state_r == ST_RUN) && (round_r != '0) && !at_last;
    cmd.last_round = fin_ok;
  end

  // Key for the next edge: the following round while running, slot zero
  // when idle or finishing, and the last slot again while stalled.
  always_comb begin
    rd_addr = '0;
    if (state_r == ST_RUN) begin
      if (!at_last) begin
        rd_addr = round_r + 1'b1;
      end else if (!fin_ok) begin
        rd_addr = LAST_RND;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (dec_fire) begin
          state_nxt = ST_RUN;
          round_nxt = '0;
        end
      end
      ST_RUN: begin
        if (!at_last) begin
          round_nxt = round_r + 1'b1;
        end else if (fin_ok) begin
          out_valid_nxt = 1'b1;
          round_nxt     = '0;
          state_nxt     = dec_fire ? ST_RUN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        round_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fin_ok |=> out_valid_r)
    else $error("finished block did not reach the output register");

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (state_r == ST_IDLE) || at_last)
    else $error("word accepted in the middle of a decryption");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (round_r <= LAST_RND))
    else $error("round counter beyond the last round");

  a_dec_starts: assert property (@(posedge clk) disable iff (!rst_n)
    dec_fire |=> (state_r == ST_RUN) && (round_r == '0))
    else $error("decryption did not start at the key addition");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    at_last && !fin_ok |=> at_last && out_valid_r)
    else $error("final round left while the output was stalled");
`endif

endmodule

`default_nettype wire

FILE: test/decrypt_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the decryption engine. Accepted key loads update a
// private copy of the round keys. Each accepted ciphertext word is decrypted
// here and queued. Each accepted plaintext word is checked against the oldest
// entry of that queue.
module decrypt_checker #(
  parameter int ROUNDS = 10
) (
  input  logic    clk,
  input  logic    rst_n,
  bc128dec_in_if  in_mon,
  bc128dec_out_if out_mon,
  output int      fail_count,
  output int      pending_words
);
  import bc128dec_pkg::*;

  localparam logic [7:0] GF_REDUCE   = 8'h1b;
  localparam logic [7:0] SBOX_AFFINE = 8'h63;

  logic [7:0]   inv_sub [256];
  logic [127:0] round_keys [ROUNDS+1];
  logic [127:0] expected_plain [$];

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] acc;
    int i;
    prod = 8'h00;
    acc = a;
    for (i = 0; i < 8; i++) begin
      if (b[i]) prod ^= acc;
      acc = xtime(acc);
    end
    return prod;
  endfunction

  // The inverse S-box is derived from the field inverse and the affine map,
  // so that it does not share a table with the design.
  initial begin
    int x;
    int y;
    logic [7:0] inv;
    logic [7:0] fwd;
    for (x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      fwd = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
            {inv[3:0], inv[7:4]} ^ SBOX_AFFINE;
      inv_sub[fwd] = 8'(x);
    end
  end

  function automatic logic [127:0] decrypt_block(input logic [127:0] cipher);
    logic [7:0]   st [16];
    logic [7:0]   sh [16];
    logic [7:0]   m9 [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    logic [7:0]   ai;
    logic [7:0]   x2;
    logic [7:0]   x4;
    logic [7:0]   x8;
    logic [127:0] acc;
    int rnd;
    int k;
    int c;
    int r;
    acc = cipher ^ round_keys[0];
    for (rnd = 1; rnd <= ROUNDS; rnd++) begin
      for (k = 0; k < 16; k++) st[k] = acc[127-8*k -: 8];
      // Byte 4c+r is row r of column c; row r rotates right by r columns.
      for (c = 0; c < 4; c++)
        for (r = 0; r < 4; r++)
          sh[4*c+r] = inv_sub[st[4*((c - r + 4) % 4) + r]];
      if (rnd < ROUNDS) begin
        for (c = 0; c < 4; c++) begin
          for (r = 0; r < 4; r++) begin
            ai = sh[4*c+r];
            x2 = xtime(ai);
            x4 = xtime(x2);
            x8 = xtime(x4);
            m9[r]  = x8 ^ ai;
            m11[r] = x8 ^ x2 ^ ai;
            m13[r] = x8 ^ x4 ^ ai;
            m14[r] = x8 ^ x4 ^ x2;
          end
          sh[4*c+0] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
          sh[4*c+1] = m9[0]  ^ m14[1] ^ m11[2] ^ m13[3];
          sh[4*c+2] = m13[0] ^ m9[1]  ^ m14[2] ^ m11[3];
          sh[4*c+3] = m11[0] ^ m13[1] ^ m9[2]  ^ m14[3];
        end
      end
      for (k = 0; k < 16; k++) acc[127-8*k -: 8] = sh[k];
      acc ^= round_keys[rnd];
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_words = 0;
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_LOAD) begin
          // Loads to slots past the last round are dropped by the engine.
          if (int'(in_mon.key_slot) <= ROUNDS)
            round_keys[in_mon.key_slot] = {in_mon.word_high, in_mon.word_low};
        end else begin
          expected_plain.push_back(decrypt_block({in_mon.word_high, in_mon.word_low}));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_plain.size() == 0) begin
          report_mismatch("unexpected plaintext word, high half", 64'h0, out_mon.plain_high);
        end else begin
          want = expected_plain.pop_front();
          if (out_mon.plain_high !== want[127:64])
            report_mismatch("plain_high", want[127:64], out_mon.plain_high);
          if (out_mon.plain_low !== want[63:0])
            report_mismatch("plain_low", want[63:0], out_mon.plain_low);
        end
      end
      pending_words = expected_plain.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// Top of the decryption engine testbench. It makes the clock and the single
// reset, drives key loads and ciphertext words on the input channel, plays
// the receiver on the output channel and gives the verdict. All prediction
// and comparison lives in the checker instantiated beside the engine.
module tb;
  import bc128dec_pkg::*;

  localparam int ROUND_COUNT      = 10;
  localparam int RANDOM_PER_PHASE = 308;
  localparam int WATCHDOG_LIMIT   = 2000;
  // After the last plaintext word, keep running for TAIL_CYCLES so that
  // a stray extra word from the engine is still seen by the checker.
  localparam int TAIL_CYCLES      = 2 * (ROUND_COUNT + 1) + 4;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   fail_count;
  int   pending_words;
  int   stall_cycles;

  bc128dec_in_if  in_chan ();
  bc128dec_out_if out_chan ();

  block_cipher_128_decrypt_top #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  decrypt_checker #(
    .ROUNDS(ROUND_COUNT)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // The receiver decides at every falling edge whether it takes a word at
  // the next rising edge. A stall percentage of zero means it never stalls.
  initial out_chan.ready = 1'b0;
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Half of a key or ciphertext word. The all-zero and all-one values are
  // favored so that the extremes keep showing up in the random part.
  function automatic logic [HALF_W-1:0] random_half();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offers one word on the input channel. The task is entered at a falling
  // edge and returns at the falling edge after the word was accepted, so
  // valid stays high across back-to-back words without being toggled.
  task automatic send_word(input logic mode, input logic [SLOT_W-1:0] slot,
                           input logic [HALF_W-1:0] high, input logic [HALF_W-1:0] low);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid     <= 1'b0;
      in_chan.word_high <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= mode;
    in_chan.key_slot  <= slot;
    in_chan.word_high <= high;
    in_chan.word_low  <= low;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // The watchdog ends the run when no word moves on either channel for too
  // long. The slowest correct run never comes close to the limit.
  initial begin
    stall_cycles = 0;
    @(posedge rst_n);
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int phase;
    int counted;
    int roll;
    int s;

    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.mode      = MODE_LOAD;
    in_chan.key_slot  = '0;
    in_chan.word_high = '0;
    in_chan.word_low  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Every round key slot is loaded before the first block,
    // since the key store holds garbage until written. Slot 0 gets all ones
    // and the last slot all zeros; the rest are random.
    for (s = 0; s <= ROUND_COUNT; s++) begin
      if (s == 0)
        send_word(MODE_LOAD, SLOT_W'(s), '1, '1);
      else if (s == ROUND_COUNT)
        send_word(MODE_LOAD, SLOT_W'(s), '0, '0);
      else
        send_word(MODE_LOAD, SLOT_W'(s), {$urandom, $urandom}, {$urandom, $urandom});
    end

    // Loads past the last slot must leave the key store untouched, which the
    // blocks that follow would reveal.
    send_word(MODE_LOAD, SLOT_W'(ROUND_COUNT + 1), {$urandom, $urandom}, {$urandom, $urandom});
    send_word(MODE_LOAD, '1, '1, '1);

    // Extreme ciphertexts. The slot field is ignored on a decrypt, so it is
    // driven to both of its extremes here.
    send_word(MODE_DECRYPT, '0, '0, '0);
    send_word(MODE_DECRYPT, '1, '1, '1);
    send_word(MODE_DECRYPT, '0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_word(MODE_DECRYPT, SLOT_W'(5), {$urandom, $urandom}, {$urandom, $urandom});

    // Swap the extremes of the first and last keys and decrypt again.
    send_word(MODE_LOAD, '0, '0, '0);
    send_word(MODE_LOAD, SLOT_W'(ROUND_COUNT), '1, '1);
    send_word(MODE_DECRYPT, '1, '1, '1);
    send_word(MODE_DECRYPT, '0, '0, '0);

    // Random part, in four phases of idling on the two sides. Most words are
    // blocks; key reloads are mixed in so that later blocks use new keys.
    // Loads to dropped slots are mixed in as noise and count like any word.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_word(MODE_DECRYPT, SLOT_W'($urandom), random_half(), random_half());
          counted++;
        end else if (roll < 93) begin
          send_word(MODE_LOAD, SLOT_W'($urandom_range(0, ROUND_COUNT)),
                    random_half(), random_half());
          counted++;
        end else begin
          send_word(MODE_LOAD, SLOT_W'($urandom_range(ROUND_COUNT + 1, 15)),
                    random_half(), random_half());
          counted++;
        end
      end
    end

    in_chan.valid <= 1'b0;

    // Drain: wait until every predicted plaintext word has come out, then
    // a little longer to catch anything extra.
    while (pending_words != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bc128dec_pkg.sv
rtl/bc128dec_if.sv
rtl/bc128dec_dp.sv
rtl/bc128dec_ctrl.sv
rtl/block_cipher_128_decrypt_top.sv
test/decrypt_checker.sv
test/tb.sv
